// ----- rtl/sts_pkg.sv -----
package sts_pkg;

    localparam int BYTE_W    = 8;
    localparam int CAP_W     = 16;
    localparam int TAG_DEPTH = 62;
    localparam int TAG_W     = $clog2(TAG_DEPTH + 1);
    localparam int TAG_AW    = $clog2(TAG_DEPTH);

    localparam logic [CAP_W-1:0] CAP_RESET = 16'd511;

    localparam logic [BYTE_W-1:0] CH_LBRACE = 8'h7B;
    localparam logic [BYTE_W-1:0] CH_RBRACE = 8'h7D;
    localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5C;
    localparam logic [BYTE_W-1:0] CH_P      = 8'h70;
    localparam logic [BYTE_W-1:0] CH_UPN    = 8'h4E;
    localparam logic [BYTE_W-1:0] CH_LON    = 8'h6E;
    localparam logic [BYTE_W-1:0] CH_H      = 8'h68;
    localparam logic [BYTE_W-1:0] CH_ZERO   = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE   = 8'h39;
    localparam logic [BYTE_W-1:0] CH_NL     = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_SPACE  = 8'h20;

    // source of a word pushed towards the output
    typedef enum logic [1:0] {
        SRC_C1  = 2'd0,
        SRC_C2  = 2'd1,
        SRC_BS  = 2'd2,
        SRC_MEM = 2'd3
    } t_src;

    typedef struct packed {
        logic load;
        logic take;
        logic push;
        t_src src;
        logic rep_inc;
        logic flush;
    } t_cmd;

    typedef struct packed {
        logic c1_v;
        logic c2_v;
        logic last;
        logic end_bs;
        logic in_tag;
        logic rep_end;
        logic can_push;
        logic out_free;
    } t_stat;

endpackage

// ----- rtl/sts_ctrl.sv -----
module sts_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_valid,
    output logic          o_s_ready,
    input  sts_pkg::t_stat i_st,
    output sts_pkg::t_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_TAKE,
        S_EMIT1,
        S_EMIT2,
        S_ENDBS,
        S_REP_RD,
        S_REP_PUSH,
        S_FLUSH
    } t_state;

    t_state r_state, n_state;
    logic   r_ready, n_ready;
    t_state w_after_emit;

    always_comb begin
        if (!i_st.last) begin
            w_after_emit = S_FLUSH;
        end else if (i_st.end_bs) begin
            w_after_emit = S_ENDBS;
        end else if (i_st.in_tag) begin
            w_after_emit = S_REP_RD;
        end else begin
            w_after_emit = S_FLUSH;
        end
    end

    always_comb begin
        n_state       = r_state;
        n_ready       = 1'b0;
        o_cmd         = '0;
        o_cmd.src     = sts_pkg::SRC_C1;
        case (r_state)
            S_IDLE: begin
                n_ready = 1'b1;
                if (i_s_valid && r_ready) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_TAKE;
                    n_ready    = 1'b0;
                end
            end
            S_TAKE: begin
                o_cmd.take = 1'b1;
                n_state    = S_EMIT1;
            end
            S_EMIT1: begin
                o_cmd.src = sts_pkg::SRC_C1;
                if (!i_st.c1_v) begin
                    n_state = S_EMIT2;
                end else if (i_st.can_push) begin
                    o_cmd.push = 1'b1;
                    n_state    = S_EMIT2;
                end
            end
            S_EMIT2: begin
                o_cmd.src = sts_pkg::SRC_C2;
                if (!i_st.c2_v) begin
                    n_state = w_after_emit;
                end else if (i_st.can_push) begin
                    o_cmd.push = 1'b1;
                    n_state    = w_after_emit;
                end
            end
            S_ENDBS: begin
                o_cmd.src = sts_pkg::SRC_BS;
                if (i_st.can_push) begin
                    o_cmd.push = 1'b1;
                    n_state    = S_FLUSH;
                end
            end
            S_REP_RD: begin
                n_state = S_REP_PUSH;
            end
            S_REP_PUSH: begin
                o_cmd.src = sts_pkg::SRC_MEM;
                if (i_st.can_push) begin
                    o_cmd.push    = 1'b1;
                    o_cmd.rep_inc = 1'b1;
                    n_state       = i_st.rep_end ? S_FLUSH : S_REP_RD;
                end
            end
            S_FLUSH: begin
                if (i_st.out_free) begin
                    o_cmd.flush = 1'b1;
                    n_state     = S_IDLE;
                    n_ready     = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ready <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ready <= n_ready;
        end
    end

    assign o_s_ready = r_ready;

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.push |-> i_st.can_push)
        else $error("push issued with no room");

    a_flush_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.flush |-> i_st.out_free)
        else $error("flush issued while output busy");

    a_load_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> o_cmd.take)
        else $error("accepted word not parsed next cycle");

endmodule

// ----- rtl/sts_datapath.sv -----
module sts_datapath (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  sts_pkg::t_cmd               i_cmd,
    output sts_pkg::t_stat              o_st,
    input  logic [sts_pkg::BYTE_W-1:0]  i_in_byte,
    input  logic                        i_byte_valid,
    input  logic                        i_end_of_text,
    input  logic                        i_cfg_we,
    input  logic [sts_pkg::CAP_W-1:0]   i_cfg_data,
    output logic                        o_m_valid,
    input  logic                        i_m_ready,
    output logic [sts_pkg::BYTE_W-1:0]  o_out_byte,
    output logic                        o_out_valid,
    output logic                        o_out_last,
    output logic                        o_tag_truncated
);

    typedef enum logic [2:0] {
        M_NORMAL     = 3'd0,
        M_NORMAL_BS  = 3'd1,
        M_TAG        = 3'd2,
        M_TAG_BS     = 3'd3,
        M_TAG_DIGITS = 3'd4
    } t_mode;

    localparam int BW = sts_pkg::BYTE_W;
    localparam int TW = sts_pkg::TAG_W;
    localparam int AW = sts_pkg::TAG_AW;
    localparam int CW = sts_pkg::CAP_W;

    logic [BW-1:0] r_mem [sts_pkg::TAG_DEPTH];
    logic [BW-1:0] r_rd;

    // item and parse state
    logic [BW-1:0] r_byte;
    logic          r_bvalid, r_last;
    t_mode         r_mode, n_mode;
    logic          r_draw, n_draw;
    logic [TW-1:0] r_len, n_len;
    logic          r_ovf, n_ovf;
    logic [CW-1:0] r_count, r_cap;
    logic [AW-1:0] r_idx;
    logic          r_c1_v, n_c1_v, r_c2_v, n_c2_v;
    logic [BW-1:0] r_c1_b, n_c1_b;

    // pending result and output register
    logic          r_pend_vld;
    logic [BW-1:0] r_pend_byte;
    logic          r_o_valid, r_o_bvalid, r_o_last, r_o_trunc;
    logic [BW-1:0] r_o_byte;

    logic          w_we;
    logic [AW-1:0] w_addr;
    logic          w_plain, w_tagtxt, w_store;
    logic          w_in_tag, w_out_free, w_trunc, w_room;
    logic          w_o_load;
    logic [BW-1:0] w_push_byte;

    assign w_in_tag   = (r_mode == M_TAG) || (r_mode == M_TAG_BS) || (r_mode == M_TAG_DIGITS);
    assign w_out_free = !r_o_valid || i_m_ready;
    assign w_trunc    = r_last && w_in_tag && r_ovf;
    assign w_room     = r_count < r_cap;
    // load the output register only when a word goes out on it
    assign w_o_load   = (i_cmd.push && w_room && r_pend_vld) ||
                        (i_cmd.flush && (r_pend_vld || r_last));

    // one parse step on the held word
    always_comb begin
        n_mode   = r_mode;
        n_draw   = r_draw;
        n_len    = r_len;
        n_ovf    = r_ovf;
        n_c1_v   = 1'b0;
        n_c1_b   = sts_pkg::CH_BSLASH;
        n_c2_v   = 1'b0;
        w_we     = 1'b0;
        w_addr   = r_len[AW-1:0];
        w_plain  = 1'b0;
        w_tagtxt = 1'b0;
        w_store  = 1'b0;
        if (r_bvalid) begin
            case (r_mode)
                M_TAG: begin
                    w_store  = 1'b1;
                    w_tagtxt = 1'b1;
                end
                M_TAG_BS: begin
                    w_store = 1'b1;
                    if (r_byte == sts_pkg::CH_P) begin
                        n_draw = 1'b0;
                        n_mode = M_TAG_DIGITS;
                    end else begin
                        w_tagtxt = 1'b1;
                    end
                end
                M_TAG_DIGITS: begin
                    w_store = 1'b1;
                    if (r_byte >= sts_pkg::CH_ZERO && r_byte <= sts_pkg::CH_NINE) begin
                        if (r_byte != sts_pkg::CH_ZERO) begin
                            n_draw = 1'b1;
                        end
                    end else begin
                        w_tagtxt = 1'b1;
                    end
                end
                M_NORMAL_BS: begin
                    n_mode = M_NORMAL;
                    if (r_byte == sts_pkg::CH_UPN || r_byte == sts_pkg::CH_LON) begin
                        n_c1_v = 1'b1;
                        n_c1_b = sts_pkg::CH_NL;
                    end else if (r_byte == sts_pkg::CH_H) begin
                        n_c1_v = 1'b1;
                        n_c1_b = sts_pkg::CH_SPACE;
                    end else begin
                        n_c1_v  = !r_draw;
                        w_plain = 1'b1;
                    end
                end
                default: begin
                    w_plain = 1'b1;
                end
            endcase
        end
        if (w_tagtxt) begin
            if (r_byte == sts_pkg::CH_RBRACE) begin
                n_mode = M_NORMAL;
            end else if (r_byte == sts_pkg::CH_BSLASH) begin
                n_mode = M_TAG_BS;
            end else begin
                n_mode = M_TAG;
            end
        end
        if (w_plain) begin
            n_mode = M_NORMAL;
            if (r_byte == sts_pkg::CH_BSLASH) begin
                n_mode = M_NORMAL_BS;
            end else if (r_byte == sts_pkg::CH_LBRACE) begin
                // open a tag: restart the store with the brace
                n_mode = M_TAG;
                n_len  = TW'(1);
                n_ovf  = 1'b0;
                w_we   = 1'b1;
                w_addr = '0;
            end else begin
                n_c2_v = !r_draw;
            end
        end
        if (w_store) begin
            if (r_len < TW'(sts_pkg::TAG_DEPTH)) begin
                w_we  = 1'b1;
                n_len = r_len + TW'(1);
            end else begin
                n_ovf = 1'b1;
            end
        end
    end

    always_comb begin
        case (i_cmd.src)
            sts_pkg::SRC_C1:  w_push_byte = r_c1_b;
            sts_pkg::SRC_C2:  w_push_byte = r_byte;
            sts_pkg::SRC_BS:  w_push_byte = sts_pkg::CH_BSLASH;
            sts_pkg::SRC_MEM: w_push_byte = r_rd;
            default:          w_push_byte = r_byte;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take && w_we) begin
            r_mem[w_addr] <= r_byte;
        end
        r_rd <= r_mem[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_byte   <= i_in_byte;
            r_bvalid <= i_byte_valid;
            r_last   <= i_end_of_text;
        end
        if (i_cmd.take) begin
            r_c1_v <= n_c1_v;
            r_c1_b <= n_c1_b;
            r_c2_v <= n_c2_v;
        end
        if (i_cmd.push && w_room) begin
            r_pend_byte <= w_push_byte;
        end
        if (w_o_load) begin
            r_o_byte   <= r_pend_vld ? r_pend_byte : '0;
            r_o_bvalid <= r_pend_vld;
            r_o_last   <= i_cmd.flush && r_last;
            r_o_trunc  <= w_trunc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= M_NORMAL;
            r_draw     <= 1'b0;
            r_len      <= '0;
            r_ovf      <= 1'b0;
            r_count    <= '0;
            r_cap      <= sts_pkg::CAP_RESET;
            r_idx      <= '0;
            r_pend_vld <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_data;
            end
            if (i_cmd.load) begin
                r_idx <= '0;
            end
            if (i_cmd.rep_inc) begin
                r_idx <= r_idx + AW'(1);
            end
            if (i_cmd.take) begin
                r_mode <= n_mode;
                r_draw <= n_draw;
                r_len  <= n_len;
                r_ovf  <= n_ovf;
            end
            // output register: refill from pending, else drain
            if (w_o_load) begin
                r_o_valid <= 1'b1;
            end else if (i_m_ready) begin
                r_o_valid <= 1'b0;
            end
            if (i_cmd.push && w_room) begin
                r_count    <= r_count + CW'(1);
                r_pend_vld <= 1'b1;
            end
            if (i_cmd.flush) begin
                r_pend_vld <= 1'b0;
                if (r_last) begin
                    r_mode  <= M_NORMAL;
                    r_draw  <= 1'b0;
                    r_len   <= '0;
                    r_ovf   <= 1'b0;
                    r_count <= '0;
                end
            end
        end
    end

    assign o_st.c1_v     = r_c1_v;
    assign o_st.c2_v     = r_c2_v;
    assign o_st.last     = r_last;
    assign o_st.end_bs   = (r_mode == M_NORMAL_BS) && !r_draw;
    assign o_st.in_tag   = w_in_tag;
    assign o_st.rep_end  = (TW'(r_idx) + TW'(1)) >= r_len;
    assign o_st.can_push = !r_pend_vld || w_out_free;
    assign o_st.out_free = w_out_free;

    assign o_m_valid       = r_o_valid;
    assign o_out_byte      = r_o_byte;
    assign o_out_valid     = r_o_bvalid;
    assign o_out_last      = r_o_last;
    assign o_tag_truncated = r_o_trunc;

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= TW'(sts_pkg::TAG_DEPTH))
        else $error("tag length beyond store");

    a_store_in_tag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.take && w_we) |-> (w_in_tag || (r_byte == sts_pkg::CH_LBRACE)))
        else $error("tag store written outside a tag");

    a_load_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load |-> !r_pend_vld)
        else $error("word accepted with a result still pending");

endmodule

// ----- rtl/subtitle_tag_stripper_unit.sv -----
// Each accepted word is parsed, emitted and flushed before the next word is taken;
//   an open tag at end of text replays each stored byte through the registered tag
//   store read port, in a read state followed by a push state for each byte.
// Input words are taken one at a time; output stalls hold the unit.
// Reset: synchronous, active low; parse state, counts and the capacity register
//   (back to 511) are cleared, tag store contents are left as they are.
module subtitle_tag_stripper_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // input word channel
    input  logic                        i_s_valid,
    output logic                        o_s_ready,
    input  logic [sts_pkg::BYTE_W-1:0]  i_in_byte,
    input  logic                        i_byte_valid,
    input  logic                        i_end_of_text,
    // result word channel
    output logic                        o_m_valid,
    input  logic                        i_m_ready,
    output logic [sts_pkg::BYTE_W-1:0]  o_out_byte,
    output logic                        o_out_valid,
    output logic                        o_out_last,
    output logic                        o_tag_truncated,
    // capacity register write
    input  logic                        i_cfg_we,
    input  logic [sts_pkg::CAP_W-1:0]   i_cfg_data
);

    // The controller walks each accepted word through parse, up to two escape
    // or text emissions, the end-of-text backslash or tag replay, and a flush.
    // The datapath keeps one result back in a pending register so that the
    // final result of a text can be marked last once nothing more follows;
    // an end word that yields nothing sends a bare end marker instead.
    sts_pkg::t_cmd  w_cmd;
    sts_pkg::t_stat w_st;

    sts_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (i_s_valid),
        .o_s_ready (o_s_ready),
        .i_st      (w_st),
        .o_cmd     (w_cmd)
    );

    sts_datapath u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_st            (w_st),
        .i_in_byte       (i_in_byte),
        .i_byte_valid    (i_byte_valid),
        .i_end_of_text   (i_end_of_text),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .o_m_valid       (o_m_valid),
        .i_m_ready       (i_m_ready),
        .o_out_byte      (o_out_byte),
        .o_out_valid     (o_out_valid),
        .o_out_last      (o_out_last),
        .o_tag_truncated (o_tag_truncated)
    );

endmodule

// ----- test/subtitle_tag_stripper_unit_tb.sv -----
module subtitle_tag_stripper_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Generous ceiling on the whole run, well above the slowest correct run
    localparam int CYCLE_LIMIT  = 400000;
    // Quiet cycles before a register write and at the end: enough to cover a word
    // that yields nothing and is still in flight
    localparam int DRAIN_CYCLES = 16;

    // Parse states of the stripper, as the predictor tracks them
    typedef enum logic [2:0] {
        PM_NORMAL,
        PM_NORMAL_BS,
        PM_TAG,
        PM_TAG_BS,
        PM_TAG_DIGITS
    } t_parse_mode;

    // One result word on the output channel
    typedef struct packed {
        logic [sts_pkg::BYTE_W-1:0] ch;
        logic                       has_byte;
        logic                       last;
        logic                       trunc;
    } t_plain_word;

    typedef logic [sts_pkg::BYTE_W-1:0] t_text [$];

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_s_valid = 1'b0;
    logic                        o_s_ready;
    logic [sts_pkg::BYTE_W-1:0]  i_in_byte = '0;
    logic                        i_byte_valid = 1'b0;
    logic                        i_end_of_text = 1'b0;
    logic                        o_m_valid;
    logic                        i_m_ready = 1'b0;
    logic [sts_pkg::BYTE_W-1:0]  o_out_byte;
    logic                        o_out_valid;
    logic                        o_out_last;
    logic                        o_tag_truncated;
    logic                        i_cfg_we = 1'b0;
    logic [sts_pkg::CAP_W-1:0]   i_cfg_data = '0;

    subtitle_tag_stripper_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_valid       (i_s_valid),
        .o_s_ready       (o_s_ready),
        .i_in_byte       (i_in_byte),
        .i_byte_valid    (i_byte_valid),
        .i_end_of_text   (i_end_of_text),
        .o_m_valid       (o_m_valid),
        .i_m_ready       (i_m_ready),
        .o_out_byte      (o_out_byte),
        .o_out_valid     (o_out_valid),
        .o_out_last      (o_out_last),
        .o_tag_truncated (o_tag_truncated),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Percentage of cycles in which each side holds off
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int fail_count    = 0;
    int cycle_count   = 0;

    // ------------------------------------------------------------------
    // Predictor: its own copy of the stripper state and the capacity
    // ------------------------------------------------------------------
    logic [sts_pkg::CAP_W-1:0]  out_cap = sts_pkg::CAP_RESET;
    t_parse_mode                pmode = PM_NORMAL;
    logic                       drawing = 1'b0;
    logic [sts_pkg::BYTE_W-1:0] tag_mem [sts_pkg::TAG_DEPTH];
    int unsigned                tag_len = 0;
    int unsigned                emit_cnt = 0;
    logic                       tag_ovf = 1'b0;

    // Words produced by the item in hand, then the queue of all words owed
    t_plain_word step_out[$];
    t_plain_word plain_expected[$];

    function automatic void clear_parse_state();
        pmode    = PM_NORMAL;
        drawing  = 1'b0;
        tag_len  = 0;
        emit_cnt = 0;
        tag_ovf  = 1'b0;
    endfunction

    // Emit one plain byte unless the capacity is used up
    function automatic void push_char(input logic [sts_pkg::BYTE_W-1:0] c);
        if (emit_cnt < out_cap) begin
            emit_cnt++;
            step_out.push_back('{ch: c, has_byte: 1'b1, last: 1'b0, trunc: 1'b0});
        end
    endfunction

    // Keep a raw tag byte for replay; past the store, only note the overflow
    function automatic void keep_tag_char(input logic [sts_pkg::BYTE_W-1:0] c);
        if (tag_len < sts_pkg::TAG_DEPTH) begin
            tag_mem[tag_len] = c;
            tag_len++;
        end else begin
            tag_ovf = 1'b1;
        end
    endfunction

    function automatic void tag_char(input logic [sts_pkg::BYTE_W-1:0] c);
        if (c == sts_pkg::CH_RBRACE) begin
            pmode = PM_NORMAL;
        end else if (c == sts_pkg::CH_BSLASH) begin
            pmode = PM_TAG_BS;
        end else begin
            pmode = PM_TAG;
        end
    endfunction

    function automatic void plain_char(input logic [sts_pkg::BYTE_W-1:0] c);
        pmode = PM_NORMAL;
        if (c == sts_pkg::CH_BSLASH) begin
            pmode = PM_NORMAL_BS;
        end else if (c == sts_pkg::CH_LBRACE) begin
            // open a fresh tag: restart the store with the brace itself
            pmode   = PM_TAG;
            tag_len = 0;
            tag_ovf = 1'b0;
            keep_tag_char(c);
        end else if (!drawing) begin
            push_char(c);
        end
    endfunction

    function automatic void take_char(input logic [sts_pkg::BYTE_W-1:0] c);
        case (pmode)
            PM_TAG: begin
                keep_tag_char(c);
                tag_char(c);
            end
            PM_TAG_BS: begin
                keep_tag_char(c);
                if (c == sts_pkg::CH_P) begin
                    drawing = 1'b0;
                    pmode   = PM_TAG_DIGITS;
                end else begin
                    tag_char(c);
                end
            end
            PM_TAG_DIGITS: begin
                keep_tag_char(c);
                if (c >= sts_pkg::CH_ZERO && c <= sts_pkg::CH_NINE) begin
                    if (c != sts_pkg::CH_ZERO) drawing = 1'b1;
                end else begin
                    tag_char(c);
                end
            end
            PM_NORMAL_BS: begin
                // escapes give newline and space even while drawing
                pmode = PM_NORMAL;
                if (c == sts_pkg::CH_UPN || c == sts_pkg::CH_LON) begin
                    push_char(sts_pkg::CH_NL);
                end else if (c == sts_pkg::CH_H) begin
                    push_char(sts_pkg::CH_SPACE);
                end else begin
                    if (!drawing) push_char(sts_pkg::CH_BSLASH);
                    plain_char(c);
                end
            end
            default: plain_char(c);
        endcase
    endfunction

    // Work out the words owed for one accepted input word and queue them
    function automatic void strip_word(input logic [sts_pkg::BYTE_W-1:0] c, input logic bv,
                                       input logic eot);
        int unsigned k;
        logic        trunc;
        step_out.delete();
        trunc = 1'b0;
        if (bv) take_char(c);
        if (eot) begin
            if (pmode == PM_NORMAL_BS) begin
                if (!drawing) push_char(sts_pkg::CH_BSLASH);
            end else if (pmode == PM_TAG || pmode == PM_TAG_BS || pmode == PM_TAG_DIGITS) begin
                // replay the unclosed tag raw, brace first
                for (k = 0; k < tag_len; k++) push_char(tag_mem[k]);
                trunc = tag_ovf;
            end
            if (step_out.size() == 0) begin
                step_out.push_back('{ch: '0, has_byte: 1'b0, last: 1'b0, trunc: 1'b0});
            end
            for (k = 0; k < step_out.size(); k++) step_out[k].trunc = trunc;
            step_out[step_out.size() - 1].last = 1'b1;
            clear_parse_state();
        end
        for (k = 0; k < step_out.size(); k++) plain_expected.push_back(step_out[k]);
    endfunction

    // ------------------------------------------------------------------
    // Result side: random back-pressure and the check of every word taken
    // ------------------------------------------------------------------
    task automatic report_field(input string fname, input int unsigned want,
                                input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_plain_word want;
        if (i_rst_n && o_m_valid && i_m_ready) begin
            if (plain_expected.size() == 0) begin
                $display("%0t: unexpected word, expected none, actual byte %0h valid %0b",
                         $time, o_out_byte, o_out_valid, " last %0b trunc %0b",
                         o_out_last, o_tag_truncated);
                fail_count++;
            end else begin
                want = plain_expected.pop_front();
                report_field("out_byte", want.ch, o_out_byte);
                report_field("out_valid", want.has_byte, o_out_valid);
                report_field("out_last", want.last, o_out_last);
                report_field("tag_truncated", want.trunc, o_tag_truncated);
            end
        end
        i_m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Watchdog: stop a hung run
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    // Offer one word and hold it until taken; valid stays high afterwards so
    // that a following word can go out back to back
    task automatic send_word(input logic [sts_pkg::BYTE_W-1:0] c, input logic bv,
                             input logic eot);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            i_s_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        i_s_valid     <= 1'b1;
        i_in_byte     <= c;
        i_byte_valid  <= bv;
        i_end_of_text <= eot;
        do @(posedge i_clk); while (!o_s_ready);
        strip_word(c, bv, eot);
    endtask

    // Send a whole text. With shuffle set, sprinkle ignored words in and
    // sometimes close with a bare end word instead of ending on the last byte.
    task automatic send_text(input t_text txt, input bit shuffle);
        int unsigned k;
        bit          bare_end;
        bare_end = (txt.size() == 0) || (shuffle && $urandom_range(0, 4) == 0);
        for (k = 0; k < txt.size(); k++) begin
            if (shuffle && $urandom_range(0, 11) == 0) send_word(8'($urandom), 1'b0, 1'b0);
            send_word(txt[k], 1'b1, !bare_end && (k == txt.size() - 1));
        end
        if (bare_end) send_word(8'($urandom), 1'b0, 1'b1);
    endtask

    // Drop valid and wait for the unit to go quiet
    task automatic settle();
        i_s_valid <= 1'b0;
        while (plain_expected.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [sts_pkg::CAP_W-1:0] value);
        settle();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        out_cap = value;
    endtask

    // Random tag content: \p with digits, escaped bytes and printable text.
    // A printable byte may be a closing brace and end the tag early.
    function automatic void add_tag_body(ref t_text txt, input int unsigned pieces);
        int unsigned i;
        int unsigned d;
        for (i = 0; i < pieces; i++) begin
            case ($urandom_range(0, 3))
                0: begin
                    txt.push_back(sts_pkg::CH_BSLASH);
                    txt.push_back(sts_pkg::CH_P);
                    for (d = $urandom_range(0, 2); d != 0; d--) begin
                        txt.push_back(sts_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
                    end
                end
                1: begin
                    txt.push_back(sts_pkg::CH_BSLASH);
                    txt.push_back(8'($urandom));
                end
                default: txt.push_back(8'($urandom_range(32, 126)));
            endcase
        end
    endfunction

    // Mostly well-formed subtitle text with random content, some noise
    function automatic t_text random_text();
        t_text       txt;
        int unsigned n_tok;
        int unsigned i;
        int unsigned j;
        n_tok = $urandom_range(1, 6);
        for (i = 0; i < n_tok; i++) begin
            case ($urandom_range(0, 9))
                0, 1, 2: txt.push_back(8'($urandom_range(32, 126)));
                3: txt.push_back(8'($urandom));
                4: begin
                    txt.push_back(sts_pkg::CH_BSLASH);
                    case ($urandom_range(0, 3))
                        0: txt.push_back(sts_pkg::CH_UPN);
                        1: txt.push_back(sts_pkg::CH_LON);
                        2: txt.push_back(sts_pkg::CH_H);
                        default: txt.push_back(8'($urandom));
                    endcase
                end
                5, 6: begin
                    txt.push_back(sts_pkg::CH_LBRACE);
                    add_tag_body(txt, $urandom_range(0, 4));
                    txt.push_back(sts_pkg::CH_RBRACE);
                end
                7: begin
                    // drawing switch
                    txt.push_back(sts_pkg::CH_LBRACE);
                    txt.push_back(sts_pkg::CH_BSLASH);
                    txt.push_back(sts_pkg::CH_P);
                    for (j = $urandom_range(0, 2); j != 0; j--) begin
                        txt.push_back(sts_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
                    end
                    txt.push_back(sts_pkg::CH_RBRACE);
                end
                8: begin
                    txt.push_back(sts_pkg::CH_BSLASH);
                    txt.push_back(8'($urandom));
                end
                default: begin
                    for (j = $urandom_range(2, 4); j != 0; j--) begin
                        txt.push_back(8'($urandom_range(32, 126)));
                    end
                end
            endcase
        end
        // leave a tag open at the end now and then, rarely a long one
        if ($urandom_range(0, 5) == 0) begin
            txt.push_back(sts_pkg::CH_LBRACE);
            add_tag_body(txt, ($urandom_range(0, 11) == 0) ? 30 : $urandom_range(0, 4));
        end
        // trailing backslash now and then
        if ($urandom_range(0, 9) == 0) txt.push_back(sts_pkg::CH_BSLASH);
        return txt;
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Escapes, drawing switches, zero and top bytes, dangling backslashes,
    // an unclosed tag, a bare end and an ignored word
    task automatic test_escapes_and_tags();
        t_text txt;
        // \N \h \x, zero byte, \n, 0xFF, backslash pending at end
        txt = '{sts_pkg::CH_BSLASH, sts_pkg::CH_UPN, sts_pkg::CH_BSLASH, sts_pkg::CH_H,
                sts_pkg::CH_BSLASH, "x", 8'h00, sts_pkg::CH_BSLASH, sts_pkg::CH_LON,
                8'hFF, sts_pkg::CH_BSLASH};
        send_text(txt, 1'b0);
        // \p01 turns drawing on: text dropped, escapes kept, last backslash dropped
        txt = '{sts_pkg::CH_LBRACE, sts_pkg::CH_BSLASH, sts_pkg::CH_P, sts_pkg::CH_ZERO, "1",
                sts_pkg::CH_RBRACE, "q", sts_pkg::CH_BSLASH, sts_pkg::CH_H,
                sts_pkg::CH_BSLASH};
        send_text(txt, 1'b0);
        // backslash before a closing brace in a tag, then a tag left open
        txt = '{sts_pkg::CH_LBRACE, sts_pkg::CH_BSLASH, sts_pkg::CH_RBRACE,
                sts_pkg::CH_LBRACE, sts_pkg::CH_BSLASH, sts_pkg::CH_P};
        send_text(txt, 1'b0);
        send_word(8'hA5, 1'b0, 1'b0);
        send_word(8'h5A, 1'b0, 1'b1);
    endtask

    // An open tag one byte longer than the store: the last byte is dropped
    // and the replay is flagged
    task automatic test_tag_overflow();
        t_text       txt;
        logic [7:0]  c;
        int unsigned k;
        txt.push_back(sts_pkg::CH_LBRACE);
        for (k = 0; k < sts_pkg::TAG_DEPTH; k++) begin
            do c = 8'($urandom); while (c == sts_pkg::CH_RBRACE);
            txt.push_back(c);
        end
        send_text(txt, 1'b0);
    endtask

    // Capacity at zero and tiny values: bytes and replays cut short
    task automatic test_capacity_limits();
        t_text txt;
        write_capacity('0);
        txt = '{"a", "b", sts_pkg::CH_LBRACE, "c"};
        send_text(txt, 1'b0);
        send_word(8'h00, 1'b0, 1'b1);
        write_capacity(16'd1);
        txt = '{"x", "y", "z"};
        send_text(txt, 1'b0);
        write_capacity(16'd2);
        txt = '{sts_pkg::CH_LBRACE, sts_pkg::CH_BSLASH, sts_pkg::CH_P, "1"};
        send_text(txt, 1'b0);
    endtask

    // Random texts under one capacity until enough text bytes have gone in
    task automatic test_random_texts(input int unsigned min_bytes,
                                     input logic [sts_pkg::CAP_W-1:0] cap);
        t_text       txt;
        int unsigned sent;
        write_capacity(cap);
        sent = 0;
        while (sent < min_bytes) begin
            if ($urandom_range(0, 7) == 0) begin
                // pure noise
                txt.delete();
                repeat ($urandom_range(1, 6)) txt.push_back(8'($urandom));
            end else begin
                txt = random_text();
            end
            send_text(txt, 1'b1);
            sent += txt.size();
        end
    endtask

    initial begin
        clear_parse_state();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 26;
        recv_idle_pct = 60;
        test_escapes_and_tags();
        test_tag_overflow();
        test_capacity_limits();
        test_random_texts(15, 16'($urandom_range(4, 24)));

        send_idle_pct = 60;
        recv_idle_pct = 26;
        test_random_texts(15, 16'hFFFF);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_texts(15, sts_pkg::CAP_RESET);

        settle();
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
